// ===== design/cea_pkg.sv =====
// Shared types and constants for the effective address unit.
// Holds word formats, result kinds and addressing mode codes; no dependencies.
package cea_pkg;

    typedef enum logic [1:0] {
        KIND_FINAL = 2'd0,
        KIND_REQ   = 2'd1,
        KIND_IMM   = 2'd2,
        KIND_ERR   = 2'd3
    } t_kind;

    localparam logic OP_COMPUTE = 1'b0;
    localparam logic OP_DATA    = 1'b1;

    localparam logic [4:0] MODE_ABS      = 5'd0;
    localparam logic [4:0] MODE_ABS_X    = 5'd1;
    localparam logic [4:0] MODE_ABS_Y    = 5'd2;
    localparam logic [4:0] MODE_LONG     = 5'd3;
    localparam logic [4:0] MODE_LONG_X   = 5'd4;
    localparam logic [4:0] MODE_ABS_IND  = 5'd5;
    localparam logic [4:0] MODE_ABS_XIND = 5'd6;
    localparam logic [4:0] MODE_DIR      = 5'd7;
    localparam logic [4:0] MODE_DIR_IND  = 5'd8;
    localparam logic [4:0] MODE_DIR_LIND = 5'd9;
    localparam logic [4:0] MODE_DIR_INDY = 5'd10;
    localparam logic [4:0] MODE_DIR_LINDY = 5'd11;
    localparam logic [4:0] MODE_DIR_X    = 5'd12;
    localparam logic [4:0] MODE_DIR_Y    = 5'd13;
    localparam logic [4:0] MODE_DIR_XIND = 5'd14;
    localparam logic [4:0] MODE_REL      = 5'd15;
    localparam logic [4:0] MODE_REL_LONG = 5'd16;
    localparam logic [4:0] MODE_STK      = 5'd17;
    localparam logic [4:0] MODE_STK_INDY = 5'd18;
    localparam logic [4:0] MODE_IMM      = 5'd19;

    localparam logic [1:0] BYTES_NONE = 2'd0;
    localparam logic [1:0] BYTES_WORD = 2'd2;
    localparam logic [1:0] BYTES_LONG = 2'd3;

    typedef struct packed {
        logic        op;
        logic [4:0]  mode;
        logic [23:0] operand;
        logic [15:0] prog_counter;
        logic [15:0] x_index;
        logic [15:0] y_index;
        logic [15:0] direct_page;
        logic [7:0]  data_bank;
        logic [15:0] stack_ptr;
        logic [23:0] read_data;
    } t_in_word;

    typedef struct packed {
        t_kind       kind;
        logic [23:0] address;
        logic [1:0]  read_bytes;
    } t_res_word;

    typedef struct packed {
        logic        valid;
        logic [4:0]  mode;
        logic [15:0] y;
        logic [7:0]  bank;
    } t_pend;

endpackage

// ===== design/cea_if.sv =====
// Handshake channels of the effective address unit: input word and result word.
// Valid/ready with flat payload; no dependencies.
interface cea_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [4:0]  mode;
    logic [23:0] operand;
    logic [15:0] prog_counter;
    logic [15:0] x_index;
    logic [15:0] y_index;
    logic [15:0] direct_page;
    logic [7:0]  data_bank;
    logic [15:0] stack_ptr;
    logic [23:0] read_data;

    modport source (
        output valid, op, mode, operand, prog_counter, x_index, y_index,
               direct_page, data_bank, stack_ptr, read_data,
        input  ready
    );
    modport sink (
        input  valid, op, mode, operand, prog_counter, x_index, y_index,
               direct_page, data_bank, stack_ptr, read_data,
        output ready
    );
endinterface

interface cea_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [23:0] address;
    logic [1:0]  read_bytes;

    modport source (output valid, kind, address, read_bytes, input ready);
    modport sink (input valid, kind, address, read_bytes, output ready);
endinterface

// ===== design/cea_calc.sv =====
// Combinational address calculation for one word plus next pending context.
// Depends on cea_pkg.
module cea_calc (
    input  cea_pkg::t_in_word  i_word,
    input  cea_pkg::t_pend     i_pend,
    output cea_pkg::t_res_word o_res,
    output cea_pkg::t_pend     o_pend
);

    logic [7:0]  op8;
    logic [15:0] op16;
    logic [23:0] babs;
    logic [15:0] dsum;
    logic [15:0] dsum_x;
    logic [15:0] sext8;
    logic [23:0] pbabs;

    assign op8    = i_word.operand[7:0];
    assign op16   = i_word.operand[15:0];
    assign babs   = {i_word.data_bank, op16};
    assign dsum   = i_word.direct_page + {8'h00, op8};
    assign dsum_x = dsum + i_word.x_index;
    assign sext8  = {{8{op8[7]}}, op8};
    assign pbabs  = {i_pend.bank, i_word.read_data[15:0]};

    always_comb begin
        o_res = '{kind: cea_pkg::KIND_FINAL, address: 24'h0,
                  read_bytes: cea_pkg::BYTES_NONE};
        o_pend = i_pend;
        if (i_word.op == cea_pkg::OP_DATA) begin
            if (!i_pend.valid) begin
                o_res.kind = cea_pkg::KIND_ERR;
            end else begin
                o_pend.valid = 1'b0;
                unique case (i_pend.mode) inside
                    cea_pkg::MODE_DIR_IND, cea_pkg::MODE_DIR_XIND: begin
                        o_res.address = pbabs;
                    end
                    cea_pkg::MODE_DIR_LIND: begin
                        o_res.address = i_word.read_data;
                    end
                    cea_pkg::MODE_DIR_INDY, cea_pkg::MODE_STK_INDY: begin
                        o_res.address = pbabs + {8'h00, i_pend.y};
                    end
                    cea_pkg::MODE_DIR_LINDY: begin
                        o_res.address = i_word.read_data + {8'h00, i_pend.y};
                    end
                    default: begin
                        o_res.address = {8'h00, i_word.read_data[15:0]};
                    end
                endcase
            end
        end else begin
            unique case (i_word.mode) inside
                cea_pkg::MODE_ABS: o_res.address = babs;
                cea_pkg::MODE_ABS_X: o_res.address = babs + {8'h00, i_word.x_index};
                cea_pkg::MODE_ABS_Y: o_res.address = babs + {8'h00, i_word.y_index};
                cea_pkg::MODE_LONG: o_res.address = i_word.operand;
                cea_pkg::MODE_LONG_X: begin
                    o_res.address = i_word.operand + {8'h00, i_word.x_index};
                end
                cea_pkg::MODE_DIR: o_res.address = {8'h00, dsum};
                cea_pkg::MODE_DIR_X: o_res.address = {8'h00, dsum_x};
                cea_pkg::MODE_DIR_Y: begin
                    o_res.address = {8'h00, 16'(dsum + i_word.y_index)};
                end
                cea_pkg::MODE_REL: begin
                    o_res.address = {8'h00, 16'(i_word.prog_counter + sext8)};
                end
                cea_pkg::MODE_REL_LONG: begin
                    o_res.address = {8'h00, 16'(i_word.prog_counter + op16)};
                end
                cea_pkg::MODE_STK: begin
                    o_res.address = {8'h00, 16'(i_word.stack_ptr + {8'h00, op8})};
                end
                cea_pkg::MODE_IMM: begin
                    o_res.kind    = cea_pkg::KIND_IMM;
                    o_res.address = {8'h00, op16};
                end
                cea_pkg::MODE_ABS_IND, cea_pkg::MODE_ABS_XIND,
                cea_pkg::MODE_DIR_IND, cea_pkg::MODE_DIR_LIND,
                cea_pkg::MODE_DIR_INDY, cea_pkg::MODE_DIR_LINDY,
                cea_pkg::MODE_DIR_XIND, cea_pkg::MODE_STK_INDY: begin
                    o_res.kind       = cea_pkg::KIND_REQ;
                    o_res.read_bytes = cea_pkg::BYTES_WORD;
                    o_pend = '{valid: 1'b1, mode: i_word.mode,
                               y: i_word.y_index, bank: i_word.data_bank};
                    case (i_word.mode) inside
                        cea_pkg::MODE_ABS_IND: o_res.address = {8'h00, op16};
                        cea_pkg::MODE_ABS_XIND: begin
                            o_res.address = {8'h00, 16'(op16 + i_word.x_index)};
                        end
                        cea_pkg::MODE_DIR_XIND: o_res.address = {8'h00, dsum_x};
                        cea_pkg::MODE_STK_INDY: begin
                            o_res.address =
                                {8'h00, 16'(i_word.stack_ptr + {8'h00, op8})};
                        end
                        cea_pkg::MODE_DIR_LIND, cea_pkg::MODE_DIR_LINDY: begin
                            o_res.address    = {8'h00, dsum};
                            o_res.read_bytes = cea_pkg::BYTES_LONG;
                        end
                        default: o_res.address = {8'h00, dsum};
                    endcase
                end
                default: o_res.kind = cea_pkg::KIND_ERR;
            endcase
        end
    end

endmodule

// ===== design/cpu_effective_address_unit.sv =====
// Channel   Dir  Payload
// i_in      in   op, mode, operand, registers, read_data
// o_out     out  kind, address, read_bytes
//
// One word per cycle while the output drains; results leave in the order their words are accepted.
// Input register feeds cea_calc, result lands in the output register.
// Pending pointer context updates as a word moves into the output register.
// Synchronous active-low reset clears valids and the pending context.
// A stalled output holds its word; the input register keeps taking words
// as long as the output register drains.
// Depends on cea_pkg, cea_if, cea_calc.
module cpu_effective_address_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cea_in_if.sink      i_in,
    cea_out_if.source   o_out
);

    logic                r_s1_vld;
    cea_pkg::t_in_word   r_s1;
    logic                r_out_vld;
    cea_pkg::t_res_word  r_out;
    cea_pkg::t_pend      r_pend;
    cea_pkg::t_res_word  n_out;
    cea_pkg::t_pend      n_pend;
    logic                s1_adv;
    logic                in_acc;

    assign s1_adv     = r_s1_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    cea_calc u_calc (
        .i_word (r_s1),
        .i_pend (r_pend),
        .o_res  (n_out),
        .o_pend (n_pend)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_pend    <= '0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
                r_pend    <= n_pend;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= '{op: i_in.op, mode: i_in.mode, operand: i_in.operand,
                      prog_counter: i_in.prog_counter, x_index: i_in.x_index,
                      y_index: i_in.y_index, direct_page: i_in.direct_page,
                      data_bank: i_in.data_bank, stack_ptr: i_in.stack_ptr,
                      read_data: i_in.read_data};
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.kind       = r_out.kind;
    assign o_out.address    = r_out.address;
    assign o_out.read_bytes = r_out.read_bytes;

`ifndef SYNTHESIS
    a_req_sets_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && n_out.kind == cea_pkg::KIND_REQ |=> r_pend.valid)
        else $error("pointer request did not leave context pending");

    a_data_clears_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1.op == cea_pkg::OP_DATA |=> !r_pend.valid)
        else $error("data word left context pending");

    a_bytes_only_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.kind != cea_pkg::KIND_REQ |->
        r_out.read_bytes == cea_pkg::BYTES_NONE)
        else $error("read byte count on a non-request result");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.kind == cea_pkg::KIND_ERR |-> r_out.address == 24'h0)
        else $error("error result with nonzero address");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for cpu_effective_address_unit: directed mode walk, random traffic with pointer
// read sequences, a steady stream and drain pauses, all checked against an in-bench predictor.
// Depends on cea_pkg, cea_if and the unit itself.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_LIMIT = 5000;
    localparam int          WALK_DATA   = 32;
    localparam logic [4:0]  MODE_UNDEF  = 5'd31;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cea_in_if  in_ch ();
    cea_out_if out_ch ();

    cpu_effective_address_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    cea_pkg::t_pend       ptr_ctx;
    cea_pkg::t_res_word   eff_addr_q[$];
    cea_pkg::t_in_word    seen_word;
    cea_pkg::t_res_word   want;
    bit          steady;
    int unsigned errors;
    int unsigned cycles = 0;
    int unsigned words_sent;
    int unsigned data_words;
    int unsigned results_checked;
    bit [31:0]   modes_hit;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Pointer context is updated as each word is predicted, in accept order.
    function automatic cea_pkg::t_res_word calc_eff_addr(input cea_pkg::t_in_word w);
        cea_pkg::t_res_word r;
        logic [15:0] dsum;
        logic [15:0] a16;
        logic [23:0] babs;
        logic [23:0] ptr_b;
        logic [1:0]  nbytes;
        r.kind       = cea_pkg::KIND_FINAL;
        r.address    = '0;
        r.read_bytes = cea_pkg::BYTES_NONE;
        dsum   = w.direct_page + 16'(w.operand[7:0]);
        babs   = {w.data_bank, w.operand[15:0]};
        a16    = '0;
        nbytes = cea_pkg::BYTES_NONE;
        if (w.op == cea_pkg::OP_DATA) begin
            if (!ptr_ctx.valid) begin
                r.kind = cea_pkg::KIND_ERR;
                return r;
            end
            ptr_b = {ptr_ctx.bank, w.read_data[15:0]};
            case (ptr_ctx.mode)
                cea_pkg::MODE_DIR_IND, cea_pkg::MODE_DIR_XIND: r.address = ptr_b;
                cea_pkg::MODE_DIR_LIND: r.address = w.read_data;
                cea_pkg::MODE_DIR_INDY, cea_pkg::MODE_STK_INDY: begin
                    r.address = ptr_b + 24'(ptr_ctx.y);
                end
                cea_pkg::MODE_DIR_LINDY: r.address = w.read_data + 24'(ptr_ctx.y);
                default: r.address = 24'(w.read_data[15:0]);
            endcase
            ptr_ctx.valid = 1'b0;
            return r;
        end
        case (w.mode)
            cea_pkg::MODE_ABS:    r.address = babs;
            cea_pkg::MODE_ABS_X:  r.address = babs + 24'(w.x_index);
            cea_pkg::MODE_ABS_Y:  r.address = babs + 24'(w.y_index);
            cea_pkg::MODE_LONG:   r.address = w.operand;
            cea_pkg::MODE_LONG_X: r.address = w.operand + 24'(w.x_index);
            cea_pkg::MODE_ABS_IND: begin
                a16    = w.operand[15:0];
                nbytes = cea_pkg::BYTES_WORD;
            end
            cea_pkg::MODE_ABS_XIND: begin
                a16    = w.operand[15:0] + w.x_index;
                nbytes = cea_pkg::BYTES_WORD;
            end
            cea_pkg::MODE_DIR:    r.address = 24'(dsum);
            cea_pkg::MODE_DIR_IND, cea_pkg::MODE_DIR_INDY: begin
                a16    = dsum;
                nbytes = cea_pkg::BYTES_WORD;
            end
            cea_pkg::MODE_DIR_LIND, cea_pkg::MODE_DIR_LINDY: begin
                a16    = dsum;
                nbytes = cea_pkg::BYTES_LONG;
            end
            cea_pkg::MODE_DIR_X: begin
                a16       = dsum + w.x_index;
                r.address = 24'(a16);
            end
            cea_pkg::MODE_DIR_Y: begin
                a16       = dsum + w.y_index;
                r.address = 24'(a16);
            end
            cea_pkg::MODE_DIR_XIND: begin
                a16    = dsum + w.x_index;
                nbytes = cea_pkg::BYTES_WORD;
            end
            cea_pkg::MODE_REL: begin
                a16       = w.prog_counter + {{8{w.operand[7]}}, w.operand[7:0]};
                r.address = 24'(a16);
            end
            cea_pkg::MODE_REL_LONG: begin
                a16       = w.prog_counter + w.operand[15:0];
                r.address = 24'(a16);
            end
            cea_pkg::MODE_STK: begin
                a16       = w.stack_ptr + 16'(w.operand[7:0]);
                r.address = 24'(a16);
            end
            cea_pkg::MODE_STK_INDY: begin
                a16    = w.stack_ptr + 16'(w.operand[7:0]);
                nbytes = cea_pkg::BYTES_WORD;
            end
            cea_pkg::MODE_IMM: begin
                r.kind    = cea_pkg::KIND_IMM;
                r.address = 24'(w.operand[15:0]);
            end
            default:        r.kind = cea_pkg::KIND_ERR;
        endcase
        if (nbytes != cea_pkg::BYTES_NONE) begin
            r.kind       = cea_pkg::KIND_REQ;
            r.address    = 24'(a16);
            r.read_bytes = nbytes;
            ptr_ctx      = '{valid: 1'b1, mode: w.mode, y: w.y_index, bank: w.data_bank};
        end
        return r;
    endfunction

    // Check results first: a result never belongs to a word accepted at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                results_checked++;
                if (eff_addr_q.size() == 0) begin
                    $error("unexpected result: kind %0d address %h", out_ch.kind,
                           out_ch.address);
                    errors++;
                end else begin
                    want = eff_addr_q.pop_front();
                    if (out_ch.kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, out_ch.kind);
                        errors++;
                    end
                    if (out_ch.address !== want.address) begin
                        $error("address: expected %h, actual %h", want.address,
                               out_ch.address);
                        errors++;
                    end
                    if (out_ch.read_bytes !== want.read_bytes) begin
                        $error("read_bytes: expected %0d, actual %0d", want.read_bytes,
                               out_ch.read_bytes);
                        errors++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                seen_word = '{op: in_ch.op, mode: in_ch.mode, operand: in_ch.operand,
                              prog_counter: in_ch.prog_counter, x_index: in_ch.x_index,
                              y_index: in_ch.y_index, direct_page: in_ch.direct_page,
                              data_bank: in_ch.data_bank, stack_ptr: in_ch.stack_ptr,
                              read_data: in_ch.read_data};
                if (in_ch.op == cea_pkg::OP_DATA) data_words++;
                else modes_hit[in_ch.mode] = 1'b1;
                eff_addr_q.push_back(calc_eff_addr(seen_word));
            end
        end
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= steady || ($urandom_range(99) >= 23);
        end
    end

    task automatic send_word(input cea_pkg::t_in_word w);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 23) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.op           <= w.op;
        in_ch.mode         <= w.mode;
        in_ch.operand      <= w.operand;
        in_ch.prog_counter <= w.prog_counter;
        in_ch.x_index      <= w.x_index;
        in_ch.y_index      <= w.y_index;
        in_ch.direct_page  <= w.direct_page;
        in_ch.data_bank    <= w.data_bank;
        in_ch.stack_ptr    <= w.stack_ptr;
        in_ch.read_data    <= w.read_data;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic wait_results(input int unsigned max_cycles);
        int unsigned n;
        n = 0;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (eff_addr_q.size() != 0 && n < max_cycles) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    function automatic cea_pkg::t_in_word rand_word(input logic op, input logic [4:0] mode);
        cea_pkg::t_in_word w;
        logic [31:0] r0, r1, r2, r3, r4;
        r0 = $urandom;
        r1 = $urandom;
        r2 = $urandom;
        r3 = $urandom;
        r4 = $urandom;
        w.op           = op;
        w.mode         = mode;
        w.operand      = r0[23:0];
        w.prog_counter = r1[15:0];
        w.x_index      = r1[31:16];
        w.y_index      = r2[15:0];
        w.direct_page  = r2[31:16];
        w.data_bank    = r0[31:24];
        w.stack_ptr    = r3[15:0];
        w.read_data    = r4[23:0];
        case ($urandom_range(15))
            0: {w.operand, w.prog_counter, w.x_index, w.y_index, w.direct_page,
                w.data_bank, w.stack_ptr, w.read_data} = '1;
            1: {w.operand, w.prog_counter, w.x_index, w.y_index, w.direct_page,
                w.data_bank, w.stack_ptr, w.read_data} = '0;
            default: ;
        endcase
        return w;
    endfunction

    // Every mode at least once, data after each pointer request; the first window has a
    // request replaced by another and a plain compute while pending, an undefined
    // mode sits inside a pending window, and the last data word has nothing pending.
    task automatic test_mode_walk();
        int                walk[31];
        cea_pkg::t_in_word w;
        walk = '{cea_pkg::MODE_DIR_LIND, cea_pkg::MODE_ABS_IND, cea_pkg::MODE_ABS, WALK_DATA,
                 cea_pkg::MODE_ABS_XIND, cea_pkg::MODE_ABS_X, WALK_DATA,
                 cea_pkg::MODE_DIR_IND, cea_pkg::MODE_ABS_Y, WALK_DATA,
                 cea_pkg::MODE_DIR_LIND, cea_pkg::MODE_LONG, WALK_DATA,
                 cea_pkg::MODE_DIR_INDY, cea_pkg::MODE_LONG_X, WALK_DATA,
                 cea_pkg::MODE_DIR_LINDY, cea_pkg::MODE_DIR, WALK_DATA,
                 cea_pkg::MODE_DIR_XIND, cea_pkg::MODE_DIR_X, WALK_DATA,
                 cea_pkg::MODE_STK_INDY, cea_pkg::MODE_DIR_Y, MODE_UNDEF, WALK_DATA,
                 cea_pkg::MODE_REL, cea_pkg::MODE_REL_LONG, cea_pkg::MODE_STK,
                 cea_pkg::MODE_IMM, WALK_DATA};
        for (int i = 0; i < 31; i++) begin
            w.op           = (walk[i] == WALK_DATA) ? cea_pkg::OP_DATA : cea_pkg::OP_COMPUTE;
            w.mode         = (walk[i] == WALK_DATA) ? cea_pkg::MODE_ABS : 5'(walk[i]);
            w.operand      = i[0] ? 24'hFFFFFF : 24'h000080;
            w.prog_counter = i[0] ? 16'hFFFF : 16'h0000;
            w.x_index      = i[0] ? 16'hFFFF : 16'h0000;
            w.y_index      = i[0] ? 16'h0000 : 16'hFFFF;
            w.direct_page  = i[0] ? 16'hFFFF : 16'h0000;
            w.data_bank    = i[0] ? 8'hFF : 8'h00;
            w.stack_ptr    = i[0] ? 16'hFFFF : 16'h0000;
            w.read_data    = i[1] ? 24'hFFFFFF : 24'h000000;
            send_word(w);
        end
    endtask

    task automatic test_random_traffic(input int unsigned n);
        int unsigned stop_at;
        int unsigned pick;
        logic [4:0]  m;
        stop_at = words_sent + n;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                send_word(rand_word(cea_pkg::OP_DATA, 5'($urandom_range(31))));
            end else if (pick < 9) begin
                send_word(rand_word(cea_pkg::OP_COMPUTE, 5'($urandom_range(31, 20))));
            end else begin
                m = 5'($urandom_range(19));
                send_word(rand_word(cea_pkg::OP_COMPUTE, m));
                if (m inside {cea_pkg::MODE_ABS_IND, cea_pkg::MODE_ABS_XIND,
                              cea_pkg::MODE_DIR_IND, cea_pkg::MODE_DIR_LIND,
                              cea_pkg::MODE_DIR_INDY, cea_pkg::MODE_DIR_LINDY,
                              cea_pkg::MODE_DIR_XIND, cea_pkg::MODE_STK_INDY}
                    && $urandom_range(9) != 0) begin
                    if ($urandom_range(3) == 0)
                        send_word(rand_word(cea_pkg::OP_COMPUTE, 5'($urandom_range(19))));
                    send_word(rand_word(cea_pkg::OP_DATA, 5'($urandom_range(31))));
                end
            end
        end
    endtask

    task automatic test_drain_pause();
        repeat (3) begin
            test_random_traffic(80);
            wait_results(DRAIN_LIMIT);
        end
    endtask

    task automatic test_steady_stream(input int unsigned n);
        steady = 1'b1;
        test_random_traffic(n);
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.op           = cea_pkg::OP_COMPUTE;
        in_ch.mode         = cea_pkg::MODE_ABS;
        in_ch.operand      = '0;
        in_ch.prog_counter = '0;
        in_ch.x_index      = '0;
        in_ch.y_index      = '0;
        in_ch.direct_page  = '0;
        in_ch.data_bank    = '0;
        in_ch.stack_ptr    = '0;
        in_ch.read_data    = '0;
        ptr_ctx            = '0;
        steady             = 1'b0;
        errors             = 0;
        words_sent         = 0;
        data_words         = 0;
        results_checked    = 0;
        modes_hit          = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_mode_walk();
        test_random_traffic(600);
        test_drain_pause();
        test_steady_stream(400);
        test_random_traffic(420);

        wait_results(DRAIN_LIMIT);
        repeat (8) @(posedge i_clk);
        if (eff_addr_q.size() != 0) begin
            $error("%0d expected results never arrived", eff_addr_q.size());
            errors += eff_addr_q.size();
        end
        $display("Covered %0d words (%0d pointer data), %0d results checked,",
                 words_sent, data_words, results_checked);
        $display("%0d of 32 mode codes exercised, with stalls, drain pauses and a steady run.",
                 $countones(modes_hit));
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/cea_pkg.sv
design/cea_if.sv
design/cea_calc.sv
design/cpu_effective_address_unit.sv
tb/sv/tb_top.sv
